// ===== rtl/pfx_pkg.sv =====
package pfx_pkg;

	localparam int ROUND_COUNT = 10;

	// philox multipliers and key schedule
	localparam logic [31:0] MUL_N   = 32'hD2511F53;
	localparam logic [31:0] MUL_C   = 32'hCD9E8D57;
	localparam logic [31:0] WEYL_LO = 32'h9E3779B9;
	localparam logic [31:0] WEYL_HI = 32'hBB67AE85;

	// float and integer codes
	localparam logic [31:0] ONE_F32   = 32'h3F800000;
	localparam logic [31:0] MANT_MASK = 32'h007FFFFF;
	localparam logic [31:0] QNAN_F32  = 32'h7FC00000;
	localparam logic [31:0] INF_F32   = 32'h7F800000;
	localparam logic [31:0] I32_INDEF = 32'h80000000;

	// register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNTER = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN     = 3'd4;

	// float datapath
	localparam int FPW       = 50;
	localparam int LZW       = 6;
	localparam int EXPW      = 10;
	localparam int SIG_W     = 24;
	localparam int BASE_W    = 10;
	localparam int EMIN_NORM = -126;
	localparam int MUL_EBIAS = 173;
	localparam int ADD_EBIAS = 175;
	localparam int ALIGN_SH  = 25;
	localparam int ALIGN_W   = SIG_W + ALIGN_SH;

	// integer remainder chain
	localparam int MOD_STEPS = 2;
	localparam int MOD_CELLS = 32 / MOD_STEPS;

	// conversion latencies
	localparam int F_LAT = 12;
	localparam int I_LAT = MOD_CELLS + 1;
	localparam int F_PAD = I_LAT - F_LAT;

	typedef struct packed {
		logic [31:0] c1;
		logic [31:0] c0;
		logic [31:0] n1;
		logic [31:0] n0;
	} pfx_blk_t;

	typedef struct packed {
		logic [31:0] k1;
		logic [31:0] k0;
	} pfx_key_t;

	typedef struct packed {
		logic nan;
		logic inf;
		logic zero;
		logic sign;
	} pfx_fcls_t;

endpackage

// ===== rtl/pfx_round_cell.sv =====
module pfx_round_cell import pfx_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  pfx_blk_t in_blk,
	input  pfx_key_t in_key,
	output logic     out_valid,
	output pfx_blk_t out_blk,
	output pfx_key_t out_key
);

	logic [63:0] pn;
	logic [63:0] pc;

	assign pn = {32'b0, in_blk.n0} * {32'b0, MUL_N};
	assign pc = {32'b0, in_blk.c0} * {32'b0, MUL_C};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_blk.n0 <= pc[63:32] ^ in_blk.n1 ^ in_key.k0;
		out_blk.n1 <= pc[31:0];
		out_blk.c0 <= pn[63:32] ^ in_blk.c1 ^ in_key.k1;
		out_blk.c1 <= pn[31:0];
		out_key.k0 <= in_key.k0 + WEYL_LO;
		out_key.k1 <= in_key.k1 + WEYL_HI;
	end

endmodule

// ===== rtl/pfx_mod_cell.sv =====
module pfx_mod_cell import pfx_pkg::*; (
	input  logic        clk,
	input  logic [31:0] mag,
	input  logic [31:0] in_rem,
	input  logic [31:0] in_bits,
	output logic [31:0] out_rem,
	output logic [31:0] out_bits
);

	logic [31:0] r;
	logic [31:0] b;
	logic [32:0] t;

	// restoring steps, dividend bits msb first
	always_comb begin
		r = in_rem;
		b = in_bits;
		t = '0;
		for (int k = 0; k < MOD_STEPS; k++) begin
			t = {r, b[31]};
			if (t >= {1'b0, mag}) begin
				t = t - {1'b0, mag};
			end
			r = t[31:0];
			b = {b[30:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		out_rem  <= r;
		out_bits <= b;
	end

endmodule

// ===== rtl/pfx_fp_round.sv =====
module pfx_fp_round import pfx_pkg::*; (
	input  logic                   clk,
	input  pfx_fcls_t              in_cls,
	input  logic [FPW-1:0]         in_mag,
	input  logic signed [EXPW-1:0] in_exp,
	output logic [31:0]            out_bits
);

	localparam logic signed [EXPW-1:0] EMIN_V = EXPW'(EMIN_NORM);

	logic [LZW-1:0] lz;

	pfx_fcls_t             cls_s1, cls_s2, cls_s3;
	logic                  zero_s1, zero_s2, zero_s3;
	logic [FPW-1:0]        mag_s1;
	logic signed [EXPW-1:0] exp_s1;
	logic [LZW-1:0]        lz_s1;
	logic [FPW-1:0]        norm_s2;
	logic signed [EXPW-1:0] x_s2;
	logic [FPW-1:0]        sh_s3;
	logic [BASE_W-1:0]     base_s3;

	logic                  den;
	logic signed [EXPW-1:0] dfull;
	logic [4:0]            d5;
	logic [FPW-1:0]        sh;
	logic                  sh_st;
	logic [BASE_W-1:0]     base;

	logic [SIG_W-1:0]      sig;
	logic                  g;
	logic                  st;
	logic [SIG_W:0]        sum;
	logic [32:0]           packed_mag;

	// leading zero count
	always_comb begin
		lz = LZW'(FPW - 1);
		for (int i = 0; i < FPW; i++) begin
			if (in_mag[i]) begin
				lz = LZW'(FPW - 1 - i);
			end
		end
	end

	always_ff @(posedge clk) begin
		cls_s1  <= in_cls;
		zero_s1 <= in_cls.zero | (in_mag == '0);
		mag_s1  <= in_mag;
		exp_s1  <= in_exp;
		lz_s1   <= lz;
	end

	always_ff @(posedge clk) begin
		cls_s2  <= cls_s1;
		zero_s2 <= zero_s1;
		norm_s2 <= mag_s1 << lz_s1;
		x_s2    <= exp_s1 + EXPW'(FPW - 1) - EXPW'(lz_s1);
	end

	// subnormal results shift right, lost bits jammed into the lsb
	always_comb begin
		den   = x_s2 < EMIN_V;
		dfull = EMIN_V - x_s2;
		d5    = den ? ((dfull > 31) ? 5'd31 : dfull[4:0]) : 5'd0;
		sh    = norm_s2 >> d5;
		sh_st = (sh << d5) != norm_s2;
		base  = den ? '0 : BASE_W'(x_s2 - EMIN_V);
	end

	always_ff @(posedge clk) begin
		cls_s3  <= cls_s2;
		zero_s3 <= zero_s2;
		sh_s3   <= {sh[FPW-1:1], sh[0] | sh_st};
		base_s3 <= base;
	end

	// round to nearest even, carry may ripple into the exponent
	always_comb begin
		sig        = sh_s3[FPW-1 -: SIG_W];
		g          = sh_s3[FPW-1-SIG_W];
		st         = |sh_s3[FPW-2-SIG_W:0];
		sum        = {1'b0, sig} + (SIG_W+1)'(g & (st | sig[0]));
		packed_mag = {base_s3, 23'b0} + 33'(sum);
	end

	always_ff @(posedge clk) begin
		if (cls_s3.nan) begin
			out_bits <= QNAN_F32;
		end else if (cls_s3.inf) begin
			out_bits <= {cls_s3.sign, INF_F32[30:0]};
		end else if (zero_s3) begin
			out_bits <= {cls_s3.sign, 31'b0};
		end else if (packed_mag >= 33'(INF_F32[30:0])) begin
			out_bits <= {cls_s3.sign, INF_F32[30:0]};
		end else begin
			out_bits <= {cls_s3.sign, packed_mag[30:0]};
		end
	end

endmodule

// ===== rtl/pfx_fp_conv.sv =====
module pfx_fp_conv import pfx_pkg::*; (
	input  logic        clk,
	input  logic [31:0] word,
	input  logic [31:0] range_bits,
	input  logic [31:0] min_bits,
	output logic [31:0] out_bits
);

	// multiply: mantissa fraction times range
	logic [31:0] fw;
	logic [22:0] f;
	logic [7:0]  er;
	logic [7:0]  er_eff;
	logic [SIG_W-1:0] sig_r;
	logic        r_nan, r_inf, r_zero;
	logic [46:0] prod;

	pfx_fcls_t             mcls_m1;
	logic [46:0]           prod_m1;
	logic signed [EXPW-1:0] mexp_m1;
	logic [31:0]           p_bits;

	assign fw     = word & MANT_MASK;
	assign f      = fw[22:0];
	assign er     = range_bits[30:23];
	assign er_eff = (er == '0) ? 8'd1 : er;
	assign sig_r  = {er != '0, range_bits[22:0]};
	assign r_nan  = (er == 8'hFF) && (range_bits[22:0] != '0);
	assign r_inf  = (er == 8'hFF) && (range_bits[22:0] == '0);
	assign r_zero = (range_bits[30:0] == '0);
	assign prod   = {24'b0, f} * {23'b0, sig_r};

	always_ff @(posedge clk) begin
		mcls_m1.nan  <= r_nan | (r_inf & (f == '0));
		mcls_m1.inf  <= r_inf & (f != '0);
		mcls_m1.zero <= r_zero | (f == '0);
		mcls_m1.sign <= range_bits[31];
		prod_m1      <= prod;
		mexp_m1      <= EXPW'({2'b00, er_eff}) - EXPW'(MUL_EBIAS);
	end

	pfx_fp_round u_mul_round (
		.clk      (clk),
		.in_cls   (mcls_m1),
		.in_mag   ({{(FPW-47){1'b0}}, prod_m1}),
		.in_exp   (mexp_m1),
		.out_bits (p_bits)
	);

	// add: product plus lower bound
	logic [7:0]  ea, eb;
	logic        a_nan, b_nan, a_inf, b_inf, a_big;
	logic [SIG_W-1:0] sig_a, sig_b;
	logic [7:0]  ea_eff, eb_eff;

	logic        nan_a1, inf_a1, isign_a1, bsign_a1, sub_a1, neg_a1;
	logic [SIG_W-1:0] sigb_a1, sigs_a1;
	logic [7:0]  ebig_a1, diff_a1;

	logic        nan_a2, inf_a2, isign_a2, bsign_a2, sub_a2, neg_a2;
	logic [7:0]  ebig_a2;
	logic [ALIGN_W-1:0] big_a2, small_a2;

	logic [5:0]  d6;
	logic [ALIGN_W-1:0] small_w, small_sh;
	logic        small_st;

	logic [FPW-1:0] r_sum;
	logic           r_zero_sum;

	pfx_fcls_t             acls_a3;
	logic [FPW-1:0]        r_a3;
	logic signed [EXPW-1:0] aexp_a3;

	assign ea     = p_bits[30:23];
	assign eb     = min_bits[30:23];
	assign a_nan  = (ea == 8'hFF) && (p_bits[22:0] != '0);
	assign b_nan  = (eb == 8'hFF) && (min_bits[22:0] != '0);
	assign a_inf  = (ea == 8'hFF) && (p_bits[22:0] == '0);
	assign b_inf  = (eb == 8'hFF) && (min_bits[22:0] == '0);
	assign a_big  = p_bits[30:0] >= min_bits[30:0];
	assign sig_a  = {ea != '0, p_bits[22:0]};
	assign sig_b  = {eb != '0, min_bits[22:0]};
	assign ea_eff = (ea == '0) ? 8'd1 : ea;
	assign eb_eff = (eb == '0) ? 8'd1 : eb;

	always_ff @(posedge clk) begin
		nan_a1   <= a_nan | b_nan | (a_inf & b_inf & (p_bits[31] != min_bits[31]));
		inf_a1   <= a_inf | b_inf;
		isign_a1 <= a_inf ? p_bits[31] : min_bits[31];
		bsign_a1 <= a_big ? p_bits[31] : min_bits[31];
		sub_a1   <= p_bits[31] ^ min_bits[31];
		neg_a1   <= p_bits[31] & min_bits[31];
		sigb_a1  <= a_big ? sig_a : sig_b;
		sigs_a1  <= a_big ? sig_b : sig_a;
		ebig_a1  <= a_big ? ea_eff : eb_eff;
		diff_a1  <= a_big ? (ea_eff - eb_eff) : (eb_eff - ea_eff);
	end

	always_comb begin
		d6       = (diff_a1 > 8'd63) ? 6'd63 : diff_a1[5:0];
		small_w  = {sigs_a1, {ALIGN_SH{1'b0}}};
		small_sh = small_w >> d6;
		small_st = (small_sh << d6) != small_w;
	end

	always_ff @(posedge clk) begin
		nan_a2   <= nan_a1;
		inf_a2   <= inf_a1;
		isign_a2 <= isign_a1;
		bsign_a2 <= bsign_a1;
		sub_a2   <= sub_a1;
		neg_a2   <= neg_a1;
		ebig_a2  <= ebig_a1;
		big_a2   <= {sigb_a1, {ALIGN_SH{1'b0}}};
		small_a2 <= {small_sh[ALIGN_W-1:1], small_sh[0] | small_st};
	end

	always_comb begin
		if (sub_a2) begin
			r_sum      = {1'b0, big_a2} - {1'b0, small_a2};
			r_zero_sum = big_a2 == small_a2;
		end else begin
			r_sum      = {1'b0, big_a2} + {1'b0, small_a2};
			r_zero_sum = (big_a2 == '0) && (small_a2 == '0);
		end
	end

	always_ff @(posedge clk) begin
		acls_a3.nan  <= nan_a2;
		acls_a3.inf  <= inf_a2;
		acls_a3.zero <= r_zero_sum;
		acls_a3.sign <= inf_a2 ? isign_a2 : (r_zero_sum ? neg_a2 : bsign_a2);
		r_a3         <= r_sum;
		aexp_a3      <= EXPW'({2'b00, ebig_a2}) - EXPW'(ADD_EBIAS);
	end

	pfx_fp_round u_add_round (
		.clk      (clk),
		.in_cls   (acls_a3),
		.in_mag   (r_a3),
		.in_exp   (aexp_a3),
		.out_bits (out_bits)
	);

endmodule

// ===== rtl/philox_uniform_generator.sv =====
// philox 4x32 counter-based uniform generator
//
// input: pulse start with element_index (counter words n0/n1); the transfer
// happens on any clock edge with start high and busy low. busy is held low:
// the datapath is a pipeline and takes a new index in every cycle.
// configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. index 0 key, 1 high counter, 2 output mode, 3 range, 4 min;
// other indexes are dropped. write only while no item is in flight.
// output: result_valid strobes for one cycle with word_0..word_3 (final n0, n1,
// c0, c1 after conversion). the receiver cannot stall; results are not held.
// throughput: one item per cycle.
// the depth is set by the row of round cells (one multiply-xor round each)
// and by the remainder chain of 16 cells, two restoring steps per cell; the
// float path (multiply, round, align, add, round) is padded to the same depth.
// reset clears the pipeline valid bits and loads the register defaults
// (range 1.0, everything else zero).
module philox_uniform_generator import pfx_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [63:0]          element_index,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data,
	output logic                 result_valid,
	output logic [31:0]          word_0,
	output logic [31:0]          word_1,
	output logic [31:0]          word_2,
	output logic [31:0]          word_3
);

	// configuration registers
	pfx_key_t    key_q;
	logic [63:0] ctr_q;
	logic        mode_q;
	logic [31:0] range_q;
	logic [31:0] min_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q   <= '0;
			ctr_q   <= '0;
			mode_q  <= 1'b0;
			range_q <= ONE_F32;
			min_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_KEY:     key_q   <= cfg_data;
				CFG_COUNTER: ctr_q   <= cfg_data;
				CFG_MODE:    mode_q  <= cfg_data[0];
				CFG_RANGE:   range_q <= cfg_data[31:0];
				CFG_MIN:     min_q   <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// row of round cells, key advances by the weyl step in each cell
	logic     rv [ROUND_COUNT+1];
	pfx_blk_t rb [ROUND_COUNT+1];
	pfx_key_t rk [ROUND_COUNT+1];

	assign rv[0]    = start & ~busy;
	assign rb[0].n0 = element_index[31:0];
	assign rb[0].n1 = element_index[63:32];
	assign rb[0].c0 = ctr_q[31:0];
	assign rb[0].c1 = ctr_q[63:32];
	assign rk[0]    = key_q;

	for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
		pfx_round_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (rv[r]),
			.in_blk    (rb[r]),
			.in_key    (rk[r]),
			.out_valid (rv[r+1]),
			.out_blk   (rb[r+1]),
			.out_key   (rk[r+1])
		);
	end

	// valid line across the conversion stages
	logic cv_q [I_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < I_LAT; j++) begin
				cv_q[j] <= 1'b0;
			end
		end else begin
			cv_q[0] <= rv[ROUND_COUNT];
			for (int j = 1; j < I_LAT; j++) begin
				cv_q[j] <= cv_q[j-1];
			end
		end
	end

	assign result_valid = cv_q[I_LAT-1];

	// modulus magnitude, negative range uses its absolute value
	logic [31:0] mag;
	assign mag = range_q[31] ? (32'd0 - range_q) : range_q;

	logic [31:0] fin [4];
	logic [31:0] res [4];

	assign fin[0] = rb[ROUND_COUNT].n0;
	assign fin[1] = rb[ROUND_COUNT].n1;
	assign fin[2] = rb[ROUND_COUNT].c0;
	assign fin[3] = rb[ROUND_COUNT].c1;

	for (genvar l = 0; l < 4; l++) begin : g_lane
		logic [31:0] f_out;
		logic [31:0] f_pad_q [F_PAD];
		logic [31:0] rem_c   [MOD_CELLS+1];
		logic [31:0] bits_c  [MOD_CELLS+1];
		logic [31:0] i_res_q;

		// float path
		pfx_fp_conv u_fp (
			.clk        (clk),
			.word       (fin[l]),
			.range_bits (range_q),
			.min_bits   (min_q),
			.out_bits   (f_out)
		);

		always_ff @(posedge clk) begin
			f_pad_q[0] <= f_out;
			for (int j = 1; j < F_PAD; j++) begin
				f_pad_q[j] <= f_pad_q[j-1];
			end
		end

		// integer path: chain of remainder cells
		assign rem_c[0]  = '0;
		assign bits_c[0] = fin[l];

		for (genvar c = 0; c < MOD_CELLS; c++) begin : g_mod
			pfx_mod_cell u_mod (
				.clk      (clk),
				.mag      (mag),
				.in_rem   (rem_c[c]),
				.in_bits  (bits_c[c]),
				.out_rem  (rem_c[c+1]),
				.out_bits (bits_c[c+1])
			);
		end

		// zero range yields the indefinite remainder
		always_ff @(posedge clk) begin
			i_res_q <= ((range_q == '0) ? I32_INDEF : rem_c[MOD_CELLS]) + min_q;
		end

		assign res[l] = mode_q ? i_res_q : f_pad_q[F_PAD-1];
	end

	assign word_0 = res[0];
	assign word_1 = res[1];
	assign word_2 = res[2];
	assign word_3 = res[3];

endmodule
